// ===== rtl/lghu_pkg.sv =====
// ----------------------------------------------------------------------------
// lghu_pkg
// Shared types and constants of the loss gradient / Hessian unit.
// ----------------------------------------------------------------------------
package lghu_pkg;

    localparam int FRAC_BITS = 16;
    localparam int DATA_W    = 32;
    localparam int ACC_W     = 48;
    // reciprocal quotient width: floor(2^(2F) / v) needs 2F+1 bits
    localparam int RECIP_W   = 2 * FRAC_BITS + 1;
    localparam int LIT_W     = $clog2(FRAC_BITS);

    localparam logic signed [63:0] ONE     = 64'sd1 <<< FRAC_BITS;
    localparam logic        [63:0] MAG_CAP = 64'h3FFF_FFFF_FFFF_FFFF;
    localparam logic        [63:0] LN2_Q28 = 64'd186065279;
    localparam logic        [4:0]  LN_SH   = 5'd28;
    localparam logic        [4:0]  SQ_SH   = 5'd30;
    localparam logic signed [63:0] ACC_MAX = 64'sh7FFF_FFFF_FFFF;
    localparam logic signed [63:0] ACC_MIN = -ACC_MAX - 64'sd1;
    localparam logic signed [63:0] S32_MAX = 64'sh7FFF_FFFF;
    localparam logic signed [63:0] S32_MIN = -S32_MAX - 64'sd1;

    typedef enum logic [2:0] {
        LM_HALF_SQ = 3'd0,
        LM_DIFF    = 3'd1,
        LM_CE      = 3'd2,
        LM_BCE     = 3'd3,
        LM_KL      = 3'd4
    } t_loss_mode;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_DISP,
        ST_MUL,
        ST_M0D,
        ST_LNORM,
        ST_LSQD,
        ST_LSCL,
        ST_LLN,
        ST_TERMD,
        ST_DIV,
        ST_GD,
        ST_SD,
        ST_HD,
        ST_FIN,
        ST_OUT
    } t_state;

endpackage

// ===== rtl/loss_gradient_hessian_unit_top.sv =====
// ----------------------------------------------------------------------------
// loss_gradient_hessian_unit_top
// Per-element loss gradient, diagonal Hessian and running vector loss.
// ----------------------------------------------------------------------------
// One word in, one word out, one element at a time. All products and quotients
// run on a single shared 32x32 multiplier (four partial products per wide
// product) and a bit-serial reciprocal divider. In cross-entropy, KL and binary
// cross-entropy mode the logarithm (normalize, then 16 squarings on the
// multiplier) dominates the time per element. Domain errors skip the
// arithmetic. The mode register must only be written while idle.
module loss_gradient_hessian_unit_top (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [2:0]                i_cfg_wdata,    // loss_mode
    input  logic                      s_axis_tvalid,
    output logic                      s_axis_tready,
    input  logic [63:0]               s_axis_tdata,   // target_value, predicted_value
    input  logic                      s_axis_tlast,   // last_element
    output logic                      m_axis_tvalid,
    input  logic                      m_axis_tready,
    output logic [111:0]              m_axis_tdata,   // gradient, hessian_diagonal, loss_total
    output logic                      m_axis_tlast,   // is_last
    output logic                      m_axis_tuser    // domain_error
);
    import lghu_pkg::*;

    t_state r_state, n_state, r_ret;
    logic [2:0]                r_mode;
    logic signed [ACC_W-1:0]   r_acc;

    logic signed [31:0]  r_x, r_y;
    logic                r_last, r_derr, r_pair, r_logx, r_lneg, r_tneg;
    logic signed [33:0]  r_a;
    logic [31:0]         r_v;
    logic [31:0]         r_lm;
    logic [4:0]          r_lk;
    logic [LIT_W-1:0]    r_lit;
    logic [FRAC_BITS-1:0] r_lfrac;
    logic signed [31:0]  r_lv;
    logic signed [63:0]  r_term, r_grad, r_hess;
    logic [RECIP_W-1:0]  r_r;
    logic [32:0]         r_rem;
    logic [5:0]          r_cnt;
    logic [63:0]         r_ma, r_mb, r_p, r_mres;
    logic [4:0]          r_msh;
    logic [1:0]          r_psel;
    logic [127:0]        r_macc;

    logic [31:0]  r_o_grad, r_o_hess;
    logic [47:0]  r_o_total;
    logic         r_o_last, r_o_derr;

    function automatic logic [63:0] f_mag(input logic signed [63:0] v);
        return v[63] ? 64'(-v) : 64'(v);
    endfunction

    function automatic logic signed [63:0] f_sgn(input logic [63:0] m, input logic neg);
        return neg ? -$signed(m) : $signed(m);
    endfunction

    function automatic logic signed [47:0] f_sat48(input logic signed [63:0] v);
        logic signed [63:0] t;
        t = (v > ACC_MAX) ? ACC_MAX : ((v < ACC_MIN) ? ACC_MIN : v);
        return t[47:0];
    endfunction

    function automatic logic [31:0] f_sat32(input logic signed [63:0] v);
        logic signed [63:0] t;
        t = (v > S32_MAX) ? S32_MAX : ((v < S32_MIN) ? S32_MIN : v);
        return t[31:0];
    endfunction

    // ---------------- shared multiplier datapath ----------------
    logic [31:0]  mul_ah, mul_bh;
    logic [127:0] pp_sh, m_sh;
    logic [63:0]  m_clamp;
    assign mul_ah = r_cnt[1] ? r_ma[63:32] : r_ma[31:0];
    assign mul_bh = r_cnt[0] ? r_mb[63:32] : r_mb[31:0];

    always_comb begin
        case (r_psel)
            2'd0:    pp_sh = {64'd0, r_p};
            2'd3:    pp_sh = {r_p, 64'd0};
            default: pp_sh = {32'd0, r_p, 32'd0};
        endcase
    end

    assign m_sh    = r_macc >> r_msh;
    assign m_clamp = (|m_sh[127:62]) ? MAG_CAP : m_sh[63:0];

    // ---------------- divider step ----------------
    logic [32:0] div_sh, div_nrem;
    logic        div_ge;
    assign div_sh   = {r_rem[31:0], r_cnt == 6'(2 * FRAC_BITS)};
    assign div_ge   = div_sh >= {1'b0, r_v};
    assign div_nrem = div_ge ? (div_sh - {1'b0, r_v}) : div_sh;

    // ---------------- misc combinational values ----------------
    logic signed [32:0] d_xy;
    logic signed [63:0] lg, ln_val, lt_val;
    logic               a_neg, derr_c, acc_last;
    logic signed [63:0] acc_sum;
    logic signed [47:0] acc_new;
    logic [63:0]        a_mag;

    assign d_xy   = 33'(r_x) - 33'(r_y);
    assign a_neg  = r_a[33];
    assign a_mag  = f_mag(64'(r_a));
    assign lg     = $signed(({59'd0, r_lk} - 64'(FRAC_BITS)) << FRAC_BITS)
                  + $signed({{(64 - FRAC_BITS){1'b0}}, r_lfrac});
    assign ln_val = f_sgn(r_mres, r_lneg);
    assign lt_val = r_logx ? (ln_val - 64'(r_lv)) : -ln_val;
    assign derr_c = (r_y <= 32'sd0)
                 || ((r_mode == LM_BCE) && (64'(r_y) >= ONE))
                 || ((r_mode == LM_KL) && (r_x < 32'sd0));
    assign acc_sum  = 64'(r_acc) + 64'(f_sat48(r_term));
    assign acc_new  = r_derr ? r_acc : f_sat48(acc_sum);
    assign acc_last = r_last;

    assign s_axis_tready = (r_state == ST_IDLE);
    assign m_axis_tvalid = (r_state == ST_OUT);
    assign m_axis_tdata  = {r_o_total, r_o_hess, r_o_grad};
    assign m_axis_tlast  = r_o_last;
    assign m_axis_tuser  = r_o_derr;

    // ---------------- sequencer ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_mode  <= LM_HALF_SQ;
            r_acc   <= '0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_mode <= i_cfg_wdata;
            end
            if (r_state == ST_FIN) begin
                r_acc <= acc_last ? '0 : acc_new;
            end
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:  if (s_axis_tvalid) n_state = ST_DISP;
            ST_DISP: begin
                case (r_mode) inside
                    LM_DIFF:                n_state = ST_FIN;
                    LM_CE, LM_BCE, LM_KL:   n_state = derr_c ? ST_FIN : ST_LNORM;
                    default:                n_state = ST_MUL;
                endcase
            end
            ST_MUL:   if (r_cnt == 6'd5) n_state = r_ret;
            ST_M0D:   n_state = ST_FIN;
            ST_LNORM: n_state = (!r_lm[31] && r_lk != 5'd0) ? ST_LNORM : ST_MUL;
            ST_LSQD:  n_state = (r_lit != '0) ? ST_MUL : ST_LSCL;
            ST_LSCL:  n_state = ST_MUL;
            ST_LLN:   n_state = (!r_logx && r_mode == LM_KL) ? ST_LNORM : ST_MUL;
            ST_TERMD: n_state = ST_DIV;
            ST_DIV:   if (r_cnt == 6'd0) n_state = ST_MUL;
            ST_GD:    n_state = ST_MUL;
            ST_SD:    n_state = ST_MUL;
            ST_HD:    n_state = (r_mode == LM_BCE && !r_pair) ? ST_LNORM : ST_FIN;
            ST_FIN:   n_state = ST_OUT;
            ST_OUT:   if (m_axis_tready) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    // ---------------- datapath registers ----------------
    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                if (s_axis_tvalid) begin
                    r_x    <= s_axis_tdata[31:0];
                    r_y    <= s_axis_tdata[63:32];
                    r_last <= s_axis_tlast;
                    r_term <= '0;
                    r_grad <= '0;
                    r_hess <= '0;
                    r_derr <= 1'b0;
                end
            end
            ST_DISP: begin
                case (r_mode) inside
                    LM_DIFF: begin
                        r_term <= 64'(r_x) - 64'(r_y);
                        r_grad <= -ONE;
                        r_hess <= '0;
                    end
                    LM_CE, LM_BCE, LM_KL: begin
                        if (derr_c) begin
                            r_derr <= 1'b1;
                        end else begin
                            r_a    <= 34'(r_x);
                            r_v    <= r_y;
                            r_pair <= 1'b0;
                            r_lm   <= r_y;
                            r_lk   <= 5'd31;
                            r_logx <= 1'b0;
                        end
                    end
                    default: begin
                        r_ma   <= f_mag(64'(d_xy));
                        r_mb   <= f_mag(64'(d_xy));
                        r_msh  <= 5'(FRAC_BITS + 1);
                        r_ret  <= ST_M0D;
                        r_grad <= 64'(r_y) - 64'(r_x);
                        r_hess <= ONE;
                    end
                endcase
            end
            ST_MUL: begin
                if (r_cnt < 6'd4) begin
                    r_p    <= 64'(mul_ah) * 64'(mul_bh);
                    r_psel <= r_cnt[1:0];
                end
                if (r_cnt != 6'd0 && r_cnt < 6'd5) begin
                    r_macc <= r_macc + pp_sh;
                end
                if (r_cnt == 6'd5) begin
                    r_mres <= m_clamp;
                end
                r_cnt <= r_cnt + 6'd1;
            end
            ST_M0D: r_term <= $signed(r_mres);
            ST_LNORM: begin
                if (!r_lm[31] && r_lk != 5'd0) begin
                    r_lm <= r_lm << 1;
                    r_lk <= r_lk - 5'd1;
                end else begin
                    // leading one now at bit 31: Q30 mantissa in [1, 2)
                    r_ma    <= 64'(r_lm >> 1);
                    r_mb    <= 64'(r_lm >> 1);
                    r_msh   <= SQ_SH;
                    r_ret   <= ST_LSQD;
                    r_lit   <= LIT_W'(FRAC_BITS - 1);
                    r_lfrac <= '0;
                end
            end
            ST_LSQD: begin
                r_lfrac[r_lit] <= r_mres[31];
                r_ma  <= r_mres[31] ? (r_mres >> 1) : r_mres;
                r_mb  <= r_mres[31] ? (r_mres >> 1) : r_mres;
                r_msh <= SQ_SH;
                r_ret <= ST_LSQD;
                r_lit <= r_lit - LIT_W'(1);
            end
            ST_LSCL: begin
                r_lneg <= lg[63];
                r_ma   <= f_mag(lg);
                r_mb   <= LN2_Q28;
                r_msh  <= LN_SH;
                r_ret  <= ST_LLN;
            end
            ST_LLN: begin
                if (!r_logx && r_mode == LM_KL) begin
                    r_lv   <= 32'(ln_val);
                    r_lm   <= r_x;
                    r_lk   <= 5'd31;
                    r_logx <= 1'b1;
                end else begin
                    r_ma   <= a_mag;
                    r_mb   <= f_mag(lt_val);
                    r_tneg <= a_neg != lt_val[63];
                    r_msh  <= 5'(FRAC_BITS);
                    r_ret  <= ST_TERMD;
                end
            end
            ST_TERMD: begin
                r_term <= r_term + f_sgn(r_mres, r_tneg);
                r_rem  <= '0;
                r_r    <= '0;
                r_cnt  <= 6'(2 * FRAC_BITS);
            end
            ST_DIV: begin
                r_rem <= div_nrem;
                r_r   <= {r_r[RECIP_W-2:0], div_ge};
                if (r_cnt != 6'd0) begin
                    r_cnt <= r_cnt - 6'd1;
                end
                r_ma  <= a_mag;
                r_mb  <= 64'({r_r[RECIP_W-2:0], div_ge});
                r_msh <= 5'(FRAC_BITS);
                r_ret <= ST_GD;
            end
            ST_GD: begin
                // first pair contributes -a/v, second pair +b/w
                r_grad <= r_pair ? (r_grad + f_sgn(r_mres, a_neg))
                                 : (r_grad - f_sgn(r_mres, a_neg));
                r_ma   <= 64'(r_r);
                r_mb   <= 64'(r_r);
                r_ret  <= ST_SD;
            end
            ST_SD: begin
                r_ma  <= a_mag;
                r_mb  <= r_mres;
                r_ret <= ST_HD;
            end
            ST_HD: begin
                r_hess <= r_hess + f_sgn(r_mres, a_neg);
                if (r_mode == LM_BCE && !r_pair) begin
                    r_pair <= 1'b1;
                    r_a    <= 34'(ONE) - 34'(r_x);
                    r_v    <= 32'(ONE - 64'(r_y));
                    r_lm   <= 32'(ONE - 64'(r_y));
                    r_lk   <= 5'd31;
                    r_logx <= 1'b0;
                end
            end
            ST_FIN: begin
                r_o_grad  <= r_derr ? 32'd0 : f_sat32(r_grad);
                r_o_hess  <= r_derr ? 32'd0 : f_sat32(r_hess);
                r_o_total <= acc_last ? acc_new : 48'd0;
                r_o_last  <= r_last;
                r_o_derr  <= r_derr;
            end
            default: ;
        endcase
        if (n_state == ST_MUL && r_state != ST_MUL) begin
            r_cnt  <= '0;
            r_macc <= '0;
        end
    end

endmodule

// ===== rtl/lghu_checker.sv =====
// ----------------------------------------------------------------------------
// lghu_checker
// Port-level checks of the loss gradient / Hessian unit.
// ----------------------------------------------------------------------------
module lghu_checker (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         s_axis_tvalid,
    input logic         s_axis_tready,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [111:0] m_axis_tdata,
    input logic         m_axis_tlast,
    input logic         m_axis_tuser
);

    // one element in flight: never ready for input while a word is offered
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(s_axis_tready && m_axis_tvalid))
        else $error("input ready while result pending");

    // an accepted element cannot produce its result in the next cycle
    a_no_instant_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !m_axis_tvalid)
        else $error("result appeared right after accept");

    // total only shown on the last element of a vector
    a_total_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tlast) |-> (m_axis_tdata[111:64] == 48'd0))
        else $error("nonzero total on non-last word");

    // domain error zeroes gradient and Hessian
    a_derr_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata[63:0] == 64'd0))
        else $error("domain error with nonzero derivatives");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("stalled output word changed");

endmodule

bind loss_gradient_hessian_unit_top lghu_checker u_lghu_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
);

// ===== verif/loss_gradient_hessian_unit_top_tb.sv =====
// ----------------------------------------------------------------------------
// loss_gradient_hessian_unit_top_tb
// Self-checking bench for the loss gradient / Hessian unit.
// ----------------------------------------------------------------------------
// Element words are streamed under every loss mode, the unknown codes too. A
// bit-exact model in the bench predicts gradient, Hessian diagonal, running
// vector loss and the domain flag for each accepted word. The monitor checks
// each output word against the oldest prediction. Both stream sides stall in
// random bursts.
module loss_gradient_hessian_unit_top_tb;
    import lghu_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WDOG_LIMIT = 20000;
    localparam int DRAIN_WAIT = 600;

    typedef struct {
        logic signed [31:0] tgt;
        logic signed [31:0] pred;
        logic               last;
    } t_elem;

    typedef struct {
        logic signed [31:0] grad;
        logic signed [31:0] hess;
        logic signed [47:0] total;
        logic               last;
        logic               derr;
    } t_result;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         i_cfg_we = 1'b0;
    logic [2:0]   i_cfg_wdata = '0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [63:0]  s_axis_tdata = '0;
    logic         s_axis_tlast = 1'b0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [111:0] m_axis_tdata;
    logic         m_axis_tlast;
    logic         m_axis_tuser;

    t_elem   elem_q[$];
    t_result result_q[$];
    logic [2:0]  mode_copy = LM_HALF_SQ;
    longint      loss_acc = 0;
    bit          idle_en = 1'b1;
    int          n_err = 0;
    int          n_in = 0;
    int          n_out = 0;
    int          n_derr = 0;
    int          n_vec = 0;
    int          s_gap = 0;
    int          r_gap = 0;
    int          wdog = 0;

    loss_gradient_hessian_unit_top u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #4 i_clk = ~i_clk;

    // ---------------- fixed-point model ----------------
    function automatic logic [63:0] abs64(longint a);
        return (a < 0) ? 64'(-a) : 64'(a);
    endfunction

    function automatic longint signed_of(logic [63:0] mag, bit neg);
        return neg ? -longint'(mag) : longint'(mag);
    endfunction

    // (a*b) >> sh on a full 128-bit product, clamped
    function automatic logic [63:0] prod_shr(logic [63:0] a, logic [63:0] b, int sh);
        logic [127:0] p;
        p = ({64'd0, a} * {64'd0, b}) >> sh;
        return (p > {64'd0, MAG_CAP}) ? MAG_CAP : p[63:0];
    endfunction

    function automatic longint q_mul(longint a, longint b);
        return signed_of(prod_shr(abs64(a), abs64(b), FRAC_BITS), (a < 0) != (b < 0));
    endfunction

    function automatic logic [63:0] q_recip(longint v);
        return (64'd1 << (2 * FRAC_BITS)) / 64'(v);
    endfunction

    function automatic longint q_div(longint a, longint v);
        return signed_of(prod_shr(abs64(a), q_recip(v), FRAC_BITS), a < 0);
    endfunction

    function automatic longint q_div_sq(longint a, longint v);
        logic [63:0] r, s;
        r = q_recip(v);
        s = prod_shr(r, r, FRAC_BITS);
        return signed_of(prod_shr(abs64(a), s, FRAC_BITS), a < 0);
    endfunction

    function automatic longint q_ln(longint v);
        logic [63:0] u, m;
        int k;
        longint frac, lg;
        u = 64'(v);
        k = 0;
        frac = 0;
        while (k < 63 && (u >> (k + 1)) != 0)
            k++;
        m = (k > 30) ? (u >> (k - 30)) : (u << (30 - k));
        for (int i = FRAC_BITS - 1; i >= 0; i--) begin
            m = (m * m) >> 30;
            if (m >= (64'd1 << 31)) begin
                m = m >> 1;
                frac = frac | (longint'(1) << i);
            end
        end
        lg = longint'(k - FRAC_BITS) * (longint'(1) << FRAC_BITS) + frac;
        return (lg * longint'(LN2_Q28)) / (longint'(1) << LN_SH);
    endfunction

    function automatic longint clip(longint v, longint lo, longint hi);
        return (v > hi) ? hi : ((v < lo) ? lo : v);
    endfunction

    // one element through the loss datapath; updates the running vector loss
    function automatic t_result loss_step(t_elem e);
        t_result r;
        longint x, y, one, g, h, t, d;
        bit derr;
        x = longint'(e.tgt);
        y = longint'(e.pred);
        one = ONE;
        g = 0; h = 0; t = 0; derr = 0;
        case (mode_copy)
            LM_DIFF: begin
                t = x - y; g = -one; h = 0;
            end
            LM_CE: begin
                if (y <= 0) derr = 1;
                else begin
                    t = -q_mul(x, q_ln(y));
                    g = -q_div(x, y);
                    h = q_div_sq(x, y);
                end
            end
            LM_BCE: begin
                if (y <= 0 || y >= one) derr = 1;
                else begin
                    t = -q_mul(x, q_ln(y)) - q_mul(one - x, q_ln(one - y));
                    g = -q_div(x, y) + q_div(one - x, one - y);
                    h = q_div_sq(x, y) + q_div_sq(one - x, one - y);
                end
            end
            LM_KL: begin
                if (y <= 0 || x < 0) derr = 1;
                else begin
                    if (x != 0) t = q_mul(x, q_ln(x) - q_ln(y));
                    g = -q_div(x, y);
                    h = q_div_sq(x, y);
                end
            end
            default: begin
                d = x - y;
                t = longint'(prod_shr(abs64(d), abs64(d), FRAC_BITS + 1));
                g = y - x;
                h = one;
            end
        endcase
        if (derr) begin
            g = 0; h = 0;
        end else begin
            loss_acc = clip(loss_acc + clip(t, ACC_MIN, ACC_MAX), ACC_MIN, ACC_MAX);
        end
        r.total = '0;
        if (e.last) begin
            r.total = loss_acc[47:0];
            loss_acc = 0;
        end
        r.grad = 32'(clip(g, S32_MIN, S32_MAX));
        r.hess = 32'(clip(h, S32_MIN, S32_MAX));
        r.last = e.last;
        r.derr = derr;
        return r;
    endfunction

    // ---------------- driver ----------------
    always @(posedge i_clk) begin
        t_elem e;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                e.tgt = s_axis_tdata[31:0];
                e.pred = s_axis_tdata[63:32];
                e.last = s_axis_tlast;
                result_q.push_back(loss_step(e));
                n_in++;
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (s_gap > 0) begin
                    s_gap--;
                    s_axis_tvalid <= 1'b0;
                end else if (elem_q.size() > 0) begin
                    e = elem_q.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata <= {e.pred, e.tgt};
                    s_axis_tlast <= e.last;
                    if (idle_en && $urandom_range(0, 7) == 0)
                        s_gap = $urandom_range(1, 14);
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // ---------------- result side ----------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else if (r_gap > 0) begin
            r_gap--;
            m_axis_tready <= 1'b0;
        end else if (idle_en && $urandom_range(0, 9) == 0) begin
            r_gap = $urandom_range(0, 13);
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    task automatic report_mismatch(string what, longint got, longint want);
        n_err++;
        $display("MISMATCH word %0d %s: got %0d expected %0d", n_out, what, got, want);
    endtask

    always @(posedge i_clk) begin
        t_result w;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (result_q.size() == 0) begin
                report_mismatch("unexpected word", 1, 0);
            end else begin
                w = result_q.pop_front();
                if (m_axis_tdata[31:0] !== w.grad)
                    report_mismatch("gradient", $signed(m_axis_tdata[31:0]), w.grad);
                if (m_axis_tdata[63:32] !== w.hess)
                    report_mismatch("hessian", $signed(m_axis_tdata[63:32]), w.hess);
                if (m_axis_tdata[111:64] !== w.total)
                    report_mismatch("loss_total", $signed(m_axis_tdata[111:64]), w.total);
                if (m_axis_tlast !== w.last)
                    report_mismatch("is_last", m_axis_tlast, w.last);
                if (m_axis_tuser !== w.derr)
                    report_mismatch("domain_error", m_axis_tuser, w.derr);
                if (w.derr) n_derr++;
                if (w.last) n_vec++;
            end
            n_out++;
        end
    end

    // stall watchdog: no word moving on either side
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            wdog <= 0;
        else
            wdog <= wdog + 1;
        if (wdog >= WDOG_LIMIT) begin
            $display("Timeout: no transfer for %0d cycles", WDOG_LIMIT);
            $display("Verification failed");
            $finish;
        end
    end

    // ---------------- stimulus ----------------
    task automatic put(longint x, longint y, bit last);
        t_elem e;
        e.tgt = x[31:0];
        e.pred = y[31:0];
        e.last = last;
        elem_q.push_back(e);
    endtask

    task automatic wait_idle();
        while (elem_q.size() > 0 || s_axis_tvalid || result_q.size() > 0)
            @(posedge i_clk);
    endtask

    task automatic set_mode(logic [2:0] m);
        wait_idle();
        repeat (DRAIN_WAIT) @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= m;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        mode_copy = m;
    endtask

    task automatic rand_elem(logic [2:0] m);
        longint one, x, y;
        int pick;
        one = ONE;
        pick = $urandom_range(0, 9);
        x = $signed($urandom());
        y = $signed($urandom());
        if (pick >= 2) begin
            case (m) inside
                LM_CE, LM_KL: begin
                    x = (pick == 2) ? 0 : $urandom_range(0, 4 * one);
                    y = (pick == 3) ? $urandom_range(1, 32'h7FFF_FFFF)
                                    : $urandom_range(1, 8 * one);
                end
                LM_BCE: begin
                    x = (pick == 2) ? 0 : $urandom_range(0, one);
                    y = $urandom_range(1, one - 1);
                end
                LM_DIFF: ;
                default: begin
                    x = $signed($urandom_range(0, 16 * one)) - 8 * one;
                    y = $signed($urandom_range(0, 16 * one)) - 8 * one;
                end
            endcase
        end
        put(x, y, ($urandom_range(0, 3) == 0) || (m == LM_BCE && pick != 4));
    endtask

    initial begin
        longint one;
        logic [2:0] plan[12];
        one = ONE;
        plan = '{LM_HALF_SQ, LM_DIFF, LM_CE, LM_BCE, LM_KL, LM_KL + 3'd1,
                 LM_KL + 3'd2, LM_KL + 3'd3, LM_CE, LM_BCE, LM_KL, LM_HALF_SQ};
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: extremes, every mode, domain edges, zero target
        put(-64'sd2147483648, 64'sd2147483647, 0);
        put(64'sd2147483647, -64'sd2147483648, 0);
        put(3 * one, one, 1);
        set_mode(LM_DIFF);
        put(-64'sd2147483648, 64'sd2147483647, 0);
        put(5 * one, 2 * one, 1);
        set_mode(LM_CE);
        put(one, 0, 0);
        put(one, -one, 0);
        put(0, one, 0);
        put(64'sd2147483647, 1, 0);
        put(2 * one, 64'sd2147483647, 1);
        set_mode(LM_BCE);
        put(one / 2, one, 1);
        put(one / 2, 0, 1);
        put(0, one - 1, 1);
        put(one, 1, 1);
        put(one / 4, one / 3, 0);
        put(one / 2, one / 2, 1);
        set_mode(LM_KL);
        put(-1, one, 0);
        put(0, one, 0);
        put(one, 0, 0);
        put(64'sd2147483647, 1, 0);
        put(one / 2, one / 3, 1);
        set_mode(LM_KL + 3'd3);
        put(one, 3 * one, 1);

        // random phases
        for (int p = 0; p < 12; p++) begin
            set_mode(plan[p]);
            idle_en = (p != 11) && ($urandom_range(0, 4) != 0);
            for (int i = 0; i < 45; i++) begin
                if (p == 3 && i == 22)
                    wait_idle();
                rand_elem(plan[p]);
            end
        end
        put(one, 2 * one, 1);

        wait_idle();
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (result_q.size() > 0)
            report_mismatch("words never delivered", 0, result_q.size());
        $display("Covered %0d elements in all eight mode codes, %0d vectors closed,",
                 n_in, n_vec);
        $display("%0d domain errors, random stalls on both stream sides.", n_derr);
        if (n_err == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/lghu_pkg.sv
rtl/loss_gradient_hessian_unit_top.sv
rtl/lghu_checker.sv
verif/loss_gradient_hessian_unit_top_tb.sv
